// ===== src/wmmf_pkg.sv =====
// shared types and constants of the window min/max filter
package wmmf_pkg;

    // pixel and register field widths
    localparam int PIX_W      = 8;
    localparam int RAD_W      = 2;
    localparam int DIM_W      = 11;
    localparam int ROW_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    typedef logic [PIX_W-1:0]      t_pix;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    // register indexes
    localparam t_cfg_idx REG_MODE   = 2'd0;
    localparam t_cfg_idx REG_RADIUS = 2'd1;
    localparam t_cfg_idx REG_WIDTH  = 2'd2;
    localparam t_cfg_idx REG_HEIGHT = 2'd3;

    // filter modes
    localparam logic MODE_MAX = 1'b0;
    localparam logic MODE_MIN = 1'b1;

    // register reset values and frame limits
    localparam logic [RAD_W-1:0] RADIUS_RST = 2'd1;
    localparam logic [DIM_W-1:0] WIDTH_RST  = 11'd1024;
    localparam logic [DIM_W-1:0] HEIGHT_RST = 11'd1024;
    localparam logic [ROW_W-1:0] MAX_HEIGHT = 11'd1024;

    // neutral values for the extremum trees
    localparam t_pix PIX_HIGHEST = 8'hFF;
    localparam t_pix PIX_LOWEST  = 8'h00;

    // result queue
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = 2;
    localparam int OUT_CNT_W = 3;

    typedef struct packed {
        t_pix pixel;
        logic eof;
    } t_res;

endpackage

// ===== src/wmmf_if.sv =====
// handshake channels of the window min/max filter
interface wmmf_pix_if import wmmf_pkg::*; ();
    logic valid;
    logic ready;
    t_pix pixel;
    logic flush;

    modport source (output valid, output pixel, output flush, input ready);
    modport sink (input valid, input pixel, input flush, output ready);
endinterface

interface wmmf_res_if import wmmf_pkg::*; ();
    logic valid;
    logic ready;
    t_pix out_pixel;
    logic end_of_frame;

    modport source (output valid, output out_pixel, output end_of_frame, input ready);
    modport sink (input valid, input out_pixel, input end_of_frame, output ready);
endinterface

interface wmmf_cfg_if import wmmf_pkg::*; ();
    logic      valid;
    logic      ready;
    t_cfg_idx  index;
    t_cfg_data data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/window_min_max_filter_unit.sv =====
// top level of the square-window grayscale min/max filter
// a result beat is offered once its input beat has passed stage b, stage c and the queue
// throughput: one beat per cycle while ready is high; the line memory is read for a column
// when the pixel is taken, written back in the next cycle, forwarded for width-one frames
// ready drops only when the four-entry result queue plus two results in flight would overflow
// reset: synchronous, active low; clears registers, counters, pipeline and queue; line memory
// is not cleared and needs no clearing pass
module window_min_max_filter_unit import wmmf_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wmmf_pix_if.sink    i_pix,
    wmmf_res_if.source  o_pix,
    wmmf_cfg_if.sink    i_cfg
);

    localparam int LINES  = 2 * MAX_RADIUS;
    localparam int WIN    = 2 * MAX_RADIUS + 1;
    localparam int CTR_N  = MAX_RADIUS + 1;
    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int WD_W   = $clog2(MAX_WIDTH + 1);
    localparam int WORD_W = PIX_W * LINES;
    localparam int LAG_W  = $clog2(MAX_RADIUS * (MAX_WIDTH + 1) + 1);

    // configuration registers
    logic             r_mode;
    logic [RAD_W-1:0] r_radius;
    logic [DIM_W-1:0] r_frame_w;
    logic [DIM_W-1:0] r_frame_h;

    // effective geometry
    logic [RAD_W-1:0] eff_r;
    logic [WD_W-1:0]  eff_w;
    logic [ROW_W-1:0] eff_h;
    logic [31:0]      diam;
    logic [LAG_W-1:0] lag_tgt;

    // position counters
    logic [ADDR_W-1:0] r_in_col,  n_in_col;
    logic [ROW_W-1:0]  r_in_row,  n_in_row;
    logic [ADDR_W-1:0] r_out_col, n_out_col;
    logic [ROW_W-1:0]  r_out_row, n_out_row;
    logic [LAG_W-1:0]  r_lag_cnt, n_lag_cnt;

    // intake decode
    logic cfg_wr, geo_wr, acc, in_frame, step, emit, lag_done;
    logic in_col_last, out_col_last, out_eof, out_border;
    t_pix in_val;

    // stage b: memory word arrives
    logic              r_b_vld, r_b_emit, r_b_border, r_b_eof;
    t_pix              r_b_pix;
    logic [ADDR_W-1:0] r_b_addr;
    logic [WORD_W-1:0] ram_rd, old_word, new_word;
    logic              r_fw_vld;
    logic [WORD_W-1:0] r_fw_data;
    logic [(LINES+1)*PIX_W-1:0] col_vals;
    logic [LINES:0]             col_mask;
    t_pix              col_max, col_min, col_ctr;

    // stage c: window extremum
    t_pix r_h_max [WIN];
    t_pix r_h_min [WIN];
    t_pix r_h_ctr [CTR_N];
    logic r_c_emit, r_c_border, r_c_eof;
    logic [WIN*PIX_W-1:0] win_vals;
    logic [WIN-1:0]       win_mask;
    t_pix win_ext, win_ctr;
    t_res res;

    // result queue
    logic [OUT_CNT_W-1:0] q_cnt;
    logic [OUT_CNT_W-1:0] load;
    t_res                 q_data;

    // configuration write port, always ready
    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid && i_cfg.ready;
    assign geo_wr      = cfg_wr && (i_cfg.index inside {REG_RADIUS, REG_WIDTH, REG_HEIGHT});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_MAX;
            r_radius  <= RADIUS_RST;
            r_frame_w <= WIDTH_RST;
            r_frame_h <= HEIGHT_RST;
        end else if (cfg_wr) begin
            case (i_cfg.index)
                REG_MODE:   r_mode    <= i_cfg.data[0];
                REG_RADIUS: r_radius  <= i_cfg.data[RAD_W-1:0];
                REG_WIDTH:  r_frame_w <= i_cfg.data;
                REG_HEIGHT: r_frame_h <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // saturated geometry
    always_comb begin
        eff_r = (32'(r_radius) > 32'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : r_radius;
        if (r_frame_w == '0) begin
            eff_w = WD_W'(1);
        end else if (32'(r_frame_w) > 32'(MAX_WIDTH)) begin
            eff_w = WD_W'(MAX_WIDTH);
        end else begin
            eff_w = WD_W'(r_frame_w);
        end
        if (r_frame_h == '0) begin
            eff_h = ROW_W'(1);
        end else if (r_frame_h > MAX_HEIGHT) begin
            eff_h = MAX_HEIGHT;
        end else begin
            eff_h = r_frame_h;
        end
    end

    assign diam = 32'({eff_r, 1'b0});

    // first output needs radius rows plus radius pixels taken in
    assign lag_tgt = LAG_W'(eff_r) * (LAG_W'(eff_w) + LAG_W'(1));

    // intake decode: flush inside the frame is dropped, pixels past the frame count as flush
    assign acc      = i_pix.valid && i_pix.ready;
    assign in_frame = r_in_row < eff_h;
    assign step     = acc && !(i_pix.flush && in_frame);
    assign in_val   = in_frame ? i_pix.pixel : PIX_LOWEST;
    assign lag_done = r_lag_cnt >= lag_tgt;
    assign emit     = step && lag_done;

    assign in_col_last  = (32'(r_in_col) + 32'd1) >= 32'(eff_w);
    assign out_col_last = (32'(r_out_col) + 32'd1) >= 32'(eff_w);
    assign out_eof      = out_col_last && ((32'(r_out_row) + 32'd1) >= 32'(eff_h));
    assign out_border   = (32'(r_out_row) < 32'(eff_r)) ||
                          ((32'(r_out_row) + 32'(eff_r)) >= 32'(eff_h)) ||
                          (32'(r_out_col) < 32'(eff_r)) ||
                          ((32'(r_out_col) + 32'(eff_r)) >= 32'(eff_w));

    // input and output raster positions
    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        n_lag_cnt = r_lag_cnt;
        if (geo_wr || (emit && out_eof)) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
            n_lag_cnt = '0;
        end else begin
            if (step) begin
                if (in_col_last) begin
                    n_in_col = '0;
                    n_in_row = r_in_row + ROW_W'(1);
                end else begin
                    n_in_col = r_in_col + ADDR_W'(1);
                end
                if (!lag_done) begin
                    n_lag_cnt = r_lag_cnt + LAG_W'(1);
                end
            end
            if (emit) begin
                if (out_col_last) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + ROW_W'(1);
                end else begin
                    n_out_col = r_out_col + ADDR_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_lag_cnt <= '0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_lag_cnt <= n_lag_cnt;
        end
    end

    // pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld  <= 1'b0;
            r_b_emit <= 1'b0;
            r_c_emit <= 1'b0;
            r_fw_vld <= 1'b0;
        end else begin
            r_b_vld  <= step;
            r_b_emit <= emit;
            r_c_emit <= r_b_emit;
            r_fw_vld <= r_b_vld && step && (r_in_col == r_b_addr);
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        r_b_pix    <= in_val;
        r_b_addr   <= r_in_col;
        r_b_border <= out_border;
        r_b_eof    <= out_eof;
        r_c_border <= r_b_border;
        r_c_eof    <= r_b_eof;
        r_fw_data  <= new_word;
    end

    // line memory: one word holds a column of all buffered rows
    wmmf_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (r_b_vld),
        .i_wr_addr (r_b_addr),
        .i_wr_data (new_word),
        .i_rd_en   (step),
        .i_rd_addr (r_in_col),
        .o_rd_data (ram_rd)
    );

    // forward the word written on the edge that read the same column
    assign old_word = r_fw_vld ? r_fw_data : ram_rd;

    // rows shift down by one within the active depth, the new pixel enters the top row
    always_comb begin
        new_word = old_word;
        if (32'd0 < diam) begin
            new_word[0 +: PIX_W] = r_b_pix;
        end
        for (int k = 1; k < LINES; k++) begin
            if (32'(k) < diam) begin
                new_word[k*PIX_W +: PIX_W] = old_word[(k-1)*PIX_W +: PIX_W];
            end
        end
    end

    // column leaves: buffered rows above, new pixel at the bottom
    always_comb begin
        col_vals = {r_b_pix, old_word};
        col_ctr  = r_b_pix;
        for (int k = 0; k < LINES; k++) begin
            col_mask[k] = 32'(k) < diam;
            if (32'(k) + 32'd1 == 32'(eff_r)) begin
                col_ctr = old_word[k*PIX_W +: PIX_W];
            end
        end
        col_mask[LINES] = 1'b1;
    end

    wmmf_reduce #(.N(LINES + 1)) u_col_max (
        .i_vals     (col_vals),
        .i_mask     (col_mask),
        .i_take_min (1'b0),
        .o_ext      (col_max)
    );

    wmmf_reduce #(.N(LINES + 1)) u_col_min (
        .i_vals     (col_vals),
        .i_mask     (col_mask),
        .i_take_min (1'b1),
        .o_ext      (col_min)
    );

    // column history, newest column at index zero
    always_ff @(posedge i_clk) begin
        if (r_b_vld) begin
            r_h_max[0] <= col_max;
            r_h_min[0] <= col_min;
            r_h_ctr[0] <= col_ctr;
            for (int j = 1; j < WIN; j++) begin
                r_h_max[j] <= r_h_max[j-1];
                r_h_min[j] <= r_h_min[j-1];
            end
            for (int j = 1; j < CTR_N; j++) begin
                r_h_ctr[j] <= r_h_ctr[j-1];
            end
        end
    end

    // window leaves by mode, center pixel from the middle column
    always_comb begin
        win_ctr = r_h_ctr[0];
        for (int j = 0; j < WIN; j++) begin
            win_vals[j*PIX_W +: PIX_W] = (r_mode == MODE_MIN) ? r_h_min[j] : r_h_max[j];
            win_mask[j] = 32'(j) <= diam;
        end
        for (int j = 0; j < CTR_N; j++) begin
            if (32'(j) == 32'(eff_r)) begin
                win_ctr = r_h_ctr[j];
            end
        end
    end

    wmmf_reduce #(.N(WIN)) u_win (
        .i_vals     (win_vals),
        .i_mask     (win_mask),
        .i_take_min (r_mode == MODE_MIN),
        .o_ext      (win_ext)
    );

    assign res.pixel = r_c_border ? win_ctr : win_ext;
    assign res.eof   = r_c_eof;

    // result queue and output channel
    wmmf_fifo u_out_q (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (r_c_emit),
        .i_push_data (res),
        .i_pop_ready (o_pix.ready),
        .o_valid     (o_pix.valid),
        .o_data      (q_data),
        .o_count     (q_cnt)
    );

    assign o_pix.out_pixel    = q_data.pixel;
    assign o_pix.end_of_frame = q_data.eof;

    // input ready: room for every result that may still land in the queue
    assign load        = q_cnt + OUT_CNT_W'(r_b_emit) + OUT_CNT_W'(r_c_emit);
    assign i_pix.ready = load < OUT_CNT_W'(OUT_DEPTH);

endmodule

// ===== src/wmmf_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
module wmmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // read returns the old word on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/wmmf_reduce.sv =====
// masked minimum or maximum over a small set of pixels, as a compare tree
module wmmf_reduce import wmmf_pkg::*; #(
    parameter int N = 7
) (
    input  logic [N*PIX_W-1:0] i_vals,
    input  logic [N-1:0]       i_mask,
    input  logic               i_take_min,
    output t_pix               o_ext
);

    localparam int P = 1 << $clog2(N);

    t_pix tree [2*P-1];
    t_pix neutral;

    assign neutral = i_take_min ? PIX_HIGHEST : PIX_LOWEST;

    // leaves, masked entries take the neutral value
    always_comb begin
        for (int i = 0; i < N; i++) begin
            tree[P-1+i] = i_mask[i] ? i_vals[i*PIX_W +: PIX_W] : neutral;
        end
        for (int i = N; i < P; i++) begin
            tree[P-1+i] = neutral;
        end
        // inner nodes, children sit at 2i+1 and 2i+2
        for (int i = P - 2; i >= 0; i--) begin
            if (i_take_min) begin
                tree[i] = (tree[2*i+1] < tree[2*i+2]) ? tree[2*i+1] : tree[2*i+2];
            end else begin
                tree[i] = (tree[2*i+1] > tree[2*i+2]) ? tree[2*i+1] : tree[2*i+2];
            end
        end
    end

    assign o_ext = tree[0];

endmodule

// ===== src/wmmf_fifo.sv =====
// small result queue between the filter pipeline and the output channel
module wmmf_fifo import wmmf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  t_res                 i_push_data,
    input  logic                 i_pop_ready,
    output logic                 o_valid,
    output t_res                 o_data,
    output logic [OUT_CNT_W-1:0] o_count
);

    t_res                 r_mem [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] r_wr_ptr;
    logic [OUT_PTR_W-1:0] r_rd_ptr;
    logic [OUT_CNT_W-1:0] r_cnt;
    logic [OUT_CNT_W-1:0] n_cnt;
    logic                 pop;

    assign pop = (r_cnt != '0) && i_pop_ready;

    // occupancy
    always_comb begin
        case ({i_push, pop})
            2'b10:   n_cnt = r_cnt + OUT_CNT_W'(1);
            2'b01:   n_cnt = r_cnt - OUT_CNT_W'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + OUT_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + OUT_PTR_W'(1);
            end
            r_cnt <= n_cnt;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_cnt;

endmodule

// ===== src/wmmf_checker.sv =====
// port-level checks of the window min/max filter, bound to the top level
module wmmf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_pixel,
    input logic       i_out_eof
);

    // no result beat right after reset
    a_quiet_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered right after reset");

    // a result appearing on an empty output comes from an earlier accepted input beat
    a_fixed_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 3))
        else $error("result beat without a matching input beat");

    // stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat withdrawn while stalled");

    // stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_pixel) && $stable(i_out_eof))
        else $error("result payload changed while stalled");

endmodule

bind window_min_max_filter_unit wmmf_checker u_wmmf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_out_pixel (o_pix.out_pixel),
    .i_out_eof   (o_pix.end_of_frame)
);
